@@ hdl/mtts_pkg.sv @@
// Shared types, constants and the tempering function of the two-stream Mersenne Twister.
// Used by the controller, the datapath and the top level; depends on nothing.
package mtts_pkg;

    typedef logic [31:0] word_t;

    localparam word_t TWIST_MATRIX = 32'h9908_b0df;
    localparam word_t HIGH_BIT     = 32'h8000_0000;
    localparam word_t LOW_BITS     = 32'h7fff_ffff;
    localparam word_t TEMPER_B     = 32'h9d2c_5680;
    localparam word_t TEMPER_C     = 32'hefc6_0000;
    localparam word_t LCG_MULT     = 32'd69069;

    localparam logic ACTION_SEED = 1'b0;
    localparam logic ACTION_DRAW = 1'b1;

    typedef struct packed {
        logic take;
        logic seed_step;
        logic rd1;
        logic rd2;
        logic twist;
        logic out_load;
    } mtts_cmd_t;

    typedef struct packed {
        logic need_seed;
        logic is_draw;
        logic seed_last;
        logic out_free;
    } mtts_status_t;

    function automatic word_t temper(input word_t x);
        word_t y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ hdl/mtts_ctrl.sv @@
// Sequencing state machine of the two-stream Mersenne Twister.
// Depends on mtts_pkg for the command and status structs.
module mtts_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mtts_pkg::mtts_status_t status,
    output mtts_pkg::mtts_cmd_t    cmd
);
    import mtts_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_SEED   = 3'd2;
    localparam logic [2:0] ST_RD1    = 3'd3;
    localparam logic [2:0] ST_RD2    = 3'd4;
    localparam logic [2:0] ST_TWIST  = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = status.need_seed ? ST_SEED : ST_RD1;
            end
            ST_SEED: begin
                cmd.seed_step = 1'b1;
                if (status.seed_last) begin
                    state_next = status.is_draw ? ST_RD1 : ST_IDLE;
                end
            end
            ST_RD1: begin
                cmd.rd1    = 1'b1;
                state_next = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd2    = 1'b1;
                state_next = ST_TWIST;
            end
            ST_TWIST: begin
                cmd.twist  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/mtts_datapath.sv @@
// State memory, read positions, seeding recurrence, twist and tempering of the generators.
// Depends on mtts_pkg; driven by mtts_ctrl through the command struct.
module mtts_datapath #(
    parameter int STATE_WORDS = 624,
    parameter int TAP_OFFSET  = 397,
    parameter int STREAMS     = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mtts_pkg::mtts_cmd_t    cmd,
    output mtts_pkg::mtts_status_t status,
    input  mtts_pkg::word_t        s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   cfg_valid,
    input  mtts_pkg::word_t        cfg_data,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output mtts_pkg::word_t        m_tdata
);
    import mtts_pkg::*;

    localparam int IDX_W     = $clog2(STATE_WORDS + 2);
    localparam int MEM_DEPTH = STREAMS * STATE_WORDS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SEL_W     = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    localparam logic [IDX_W-1:0]   USED_UP   = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0]   UNSEEDED  = IDX_W'(STATE_WORDS + 1);
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0]   WRAP_FROM = IDX_W'(STATE_WORDS - TAP_OFFSET);
    localparam logic [IDX_W:0]     TAP_W     = (IDX_W + 1)'(TAP_OFFSET);
    localparam logic [IDX_W:0]     WORDS_W   = (IDX_W + 1)'(STATE_WORDS);
    localparam logic [ADDR_W-1:0]  WORDS_A   = ADDR_W'(STATE_WORDS);

    word_t mem_words [MEM_DEPTH];

    word_t             default_seed_reg;
    logic [IDX_W-1:0]  pos_reg [STREAMS];
    logic [SEL_W-1:0]  sel_reg;
    logic [ADDR_W-1:0] base_reg;
    logic              draw_reg;
    word_t             cur_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  k_reg;
    word_t             wk_reg;
    word_t             v_reg;
    word_t             rd_a_reg;
    word_t             rd_b_reg;
    logic              m_tvalid_reg;
    word_t             m_tdata_reg;

    logic [SEL_W-1:0]  take_sel;
    word_t             seed_word;
    logic [IDX_W-1:0]  pos_cur;
    logic [IDX_W-1:0]  k_first;
    logic [IDX_W-1:0]  k_plus1;
    logic [IDX_W:0]    k_tap_sum;
    logic [IDX_W-1:0]  k_tap;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_w;
    word_t             mix_y;
    word_t             twist_v;

    assign take_sel  = (STREAMS > 1) ? SEL_W'(s_tuser[1]) : '0;
    assign seed_word = (s_tuser[0] == ACTION_DRAW || s_tdata == '0) ? default_seed_reg : s_tdata;
    assign pos_cur   = pos_reg[sel_reg];
    assign k_first   = (pos_cur >= USED_UP) ? '0 : pos_cur;
    assign k_plus1   = (k_reg == LAST_IDX) ? '0 : k_reg + 1'b1;
    assign k_tap_sum = {1'b0, k_reg} + TAP_W;
    assign k_tap     = (k_reg >= WRAP_FROM) ? IDX_W'(k_tap_sum - WORDS_W) : IDX_W'(k_tap_sum);

    assign addr_a = base_reg + (cmd.rd2 ? ADDR_W'(k_plus1) : ADDR_W'(k_first));
    assign addr_b = base_reg + ADDR_W'(k_tap);
    assign addr_w = base_reg + (cmd.twist ? ADDR_W'(k_reg) : ADDR_W'(idx_reg));

    assign mix_y   = (wk_reg & HIGH_BIT) | (rd_a_reg & LOW_BITS);
    assign twist_v = rd_b_reg ^ (mix_y >> 1) ^ (mix_y[0] ? TWIST_MATRIX : '0);

    always_ff @(posedge aclk) begin
        if (cmd.seed_step || cmd.twist) begin
            mem_words[addr_w] <= cmd.twist ? twist_v : cur_reg;
        end
        rd_a_reg <= mem_words[addr_a];
        rd_b_reg <= mem_words[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            sel_reg  <= take_sel;
            base_reg <= ADDR_W'(take_sel) * WORDS_A;
            draw_reg <= s_tuser[0];
            cur_reg  <= seed_word;
            idx_reg  <= '0;
        end else if (cmd.seed_step) begin
            cur_reg <= cur_reg * LCG_MULT;
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.rd1) begin
            k_reg <= k_first;
        end
        if (cmd.rd2) begin
            wk_reg <= rd_a_reg;
        end
        if (cmd.twist) begin
            v_reg <= twist_v;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= temper(v_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_seed_reg <= 32'd4357;
            m_tvalid_reg     <= 1'b0;
            for (int i = 0; i < STREAMS; i++) begin
                pos_reg[i] <= UNSEEDED;
            end
        end else begin
            if (cfg_valid) begin
                default_seed_reg <= cfg_data;
            end
            if (cmd.seed_step && idx_reg == LAST_IDX) begin
                pos_reg[sel_reg] <= USED_UP;
            end else if (cmd.twist) begin
                pos_reg[sel_reg] <= k_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.need_seed = (draw_reg == ACTION_SEED) || (pos_cur == UNSEEDED);
    assign status.is_draw   = draw_reg;
    assign status.seed_last = (idx_reg == LAST_IDX);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("Result loaded over a word that is still waiting.");

    a_seed_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.seed_step |-> (idx_reg <= LAST_IDX))
        else $error("Seeding ran past the end of the state.");

    a_twist_seeded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd1 |-> (pos_cur != UNSEEDED))
        else $error("Draw started on a stream that was never seeded.");

    a_twist_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.twist |=> (pos_reg[sel_reg] == $past(k_reg) + 1'b1))
        else $error("Read position not advanced after a draw.");

endmodule

@@ hdl/mersenne_twister_two_stream_unit.sv @@
// A draw of a seeded stream passes from acceptance through the states DECODE, RD1, RD2,
// TWIST and OUT; OUT registers its word once the output is free. A seed word writes one
// state word per cycle through the single write port; a draw on a never-seeded stream
// first seeds it. Each draw twists one state word, read in RD1 and RD2 from the two memory read ports.
// Reset marks every stream unseeded and sets default_seed to 4357; the state memory is
// not cleared. Top level of the two-stream Mersenne Twister; depends on mtts_pkg.
module mersenne_twister_two_stream_unit #(
    parameter int STATE_WORDS = 624,
    parameter int TAP_OFFSET  = 397,
    parameter int STREAMS     = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  mtts_pkg::word_t s_tdata,   // seed_value
    input  logic [1:0]      s_tuser,   // action, stream
    output logic            m_tvalid,
    input  logic            m_tready,
    output mtts_pkg::word_t m_tdata,   // random_word
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  mtts_pkg::word_t cfg_data   // default_seed
);
    import mtts_pkg::*;

    mtts_cmd_t    cmd;
    mtts_status_t status;

    assign cfg_ready = 1'b1;

    mtts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mtts_datapath #(
        .STATE_WORDS (STATE_WORDS),
        .TAP_OFFSET  (TAP_OFFSET),
        .STREAMS     (STREAMS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the two-stream Mersenne Twister unit: a scoreboard class predicts
// every random word from the accepted seed and draw words. Depends on mtts_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import mtts_pkg::*;

    localparam int     STATE_WORDS   = 624;
    localparam int     TAP_OFFSET    = 397;
    localparam int     STREAMS       = 2;
    localparam int     SETTLE_CYCLES = 2 * STATE_WORDS + 16;
    localparam longint CYCLE_LIMIT   = 1_000_000;

    class twister_scoreboard;
        word_t       state_words [STREAMS][STATE_WORDS];
        int unsigned next_index [STREAMS];
        word_t       default_seed;
        word_t       expected_words [$];
        int unsigned mismatches;
        int unsigned seeds_seen;
        int unsigned draws_seen;
        int unsigned twists_done;

        function new();
            default_seed = 32'd4357;
            for (int s = 0; s < STREAMS; s++) begin
                next_index[s] = STATE_WORDS + 1;
            end
            mismatches  = 0;
            seeds_seen  = 0;
            draws_seen  = 0;
            twists_done = 0;
        endfunction

        function void fill_state(int s, word_t seed);
            word_t start;
            start = (seed == 32'd0) ? default_seed : seed;
            state_words[s][0] = start;
            for (int i = 1; i < STATE_WORDS; i++) begin
                state_words[s][i] = state_words[s][i - 1] * LCG_MULT;
            end
            next_index[s] = STATE_WORDS;
        endfunction

        function void twist_state(int s);
            word_t mixed;
            word_t folded;
            for (int k = 0; k < STATE_WORDS; k++) begin
                mixed  = (state_words[s][k] & HIGH_BIT) |
                         (state_words[s][(k + 1) % STATE_WORDS] & LOW_BITS);
                folded = state_words[s][(k + TAP_OFFSET) % STATE_WORDS] ^ (mixed >> 1);
                if (mixed[0]) begin
                    folded = folded ^ TWIST_MATRIX;
                end
                state_words[s][k] = folded;
            end
            next_index[s] = 0;
            twists_done++;
        endfunction

        function word_t temper_word(word_t raw);
            word_t t;
            t = raw ^ (raw >> 11);
            t = t ^ ((t << 7) & TEMPER_B);
            t = t ^ ((t << 15) & TEMPER_C);
            t = t ^ (t >> 18);
            return t;
        endfunction

        function void note_item(logic action, logic stream, word_t seed_value);
            int s;
            s = int'(stream) % STREAMS;
            if (action == ACTION_SEED) begin
                fill_state(s, seed_value);
                seeds_seen++;
            end else begin
                if (next_index[s] >= STATE_WORDS) begin
                    if (next_index[s] != STATE_WORDS) begin
                        fill_state(s, 32'd0);
                    end
                    twist_state(s);
                end
                expected_words.push_back(temper_word(state_words[s][next_index[s]]));
                next_index[s]++;
                draws_seen++;
            end
        endfunction

        function void check_word(word_t actual);
            word_t wanted;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected random_word %h with nothing outstanding.", actual);
                end
            end else begin
                wanted = expected_words.pop_front();
                if (wanted !== actual) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("random_word mismatch: expected %h, got %h.", wanted, actual);
                    end
                end
            end
        endfunction
    endclass

    logic   aclk;
    logic   aresetn;
    logic   s_tvalid;
    logic   s_tready;
    word_t  s_tdata;
    logic [1:0] s_tuser;
    logic   m_tvalid;
    logic   m_tready;
    word_t  m_tdata;
    logic   cfg_valid;
    logic   cfg_ready;
    word_t  cfg_data;

    twister_scoreboard sb;
    longint      cycle_count;
    bit          calm;
    int unsigned out_stall;
    int unsigned settings_used;

    mersenne_twister_two_stream_unit #(
        .STATE_WORDS(STATE_WORDS),
        .TAP_OFFSET (TAP_OFFSET),
        .STREAMS    (STREAMS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_item(s_tuser[0], s_tuser[1], s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_word(m_tdata);
                out_stall = calm ? 0 : $urandom_range(0, 3);
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (out_stall > 0) begin
            m_tready <= 1'b0;
            out_stall--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic action, input logic stream, input word_t value);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= {stream, action};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle_all();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_default_seed(input word_t value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.default_seed = value;
        settings_used++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input word_t seed_setting, input int items,
                             input int seed_pct, input int first_stream_pct);
        logic  action;
        logic  stream;
        word_t value;
        settle_all();
        write_default_seed(seed_setting);
        send_item(ACTION_SEED, 1'b0, 32'd0);
        send_item(ACTION_SEED, 1'b1, 32'd0);
        for (int i = 0; i < items; i++) begin
            action = ($urandom_range(0, 99) < seed_pct) ? ACTION_SEED : ACTION_DRAW;
            stream = ($urandom_range(0, 99) < first_stream_pct) ? 1'b0 : 1'b1;
            value  = $urandom;
            if (action == ACTION_SEED) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: value = 32'd0;
                    3:       value = 32'hffff_ffff;
                    4:       value = 32'd1;
                    default: ;
                endcase
            end
            send_item(action, stream, value);
        end
    endtask

    initial begin
        sb            = new();
        cycle_count   = 0;
        calm          = 1'b0;
        out_stall     = 0;
        settings_used = 1;
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Never-seeded streams seed themselves from the reset default first.
        send_item(ACTION_DRAW, 1'b0, 32'h0000_0000);
        send_item(ACTION_DRAW, 1'b0, 32'hffff_ffff);
        send_item(ACTION_DRAW, 1'b1, 32'h1234_5678);
        send_item(ACTION_SEED, 1'b0, 32'd0);
        send_item(ACTION_DRAW, 1'b0, 32'd0);
        send_item(ACTION_SEED, 1'b1, 32'hffff_ffff);
        send_item(ACTION_DRAW, 1'b1, 32'hffff_ffff);
        send_item(ACTION_SEED, 1'b0, 32'd1);
        send_item(ACTION_DRAW, 1'b0, 32'd1);
        send_item(ACTION_SEED, 1'b1, 32'h8000_0000);
        send_item(ACTION_DRAW, 1'b1, 32'h8000_0000);
        send_item(ACTION_SEED, 1'b0, 32'h7fff_ffff);
        send_item(ACTION_DRAW, 1'b0, 32'h0000_0000);
        send_item(ACTION_DRAW, 1'b0, 32'h0000_0000);
        send_item(ACTION_SEED, 1'b1, 32'haaaa_aaaa);
        send_item(ACTION_DRAW, 1'b1, 32'h5555_5555);
        send_item(ACTION_SEED, 1'b0, 32'h5555_5555);
        send_item(ACTION_DRAW, 1'b0, 32'haaaa_aaaa);
        send_item(ACTION_DRAW, 1'b1, 32'hffff_ffff);
        send_item(ACTION_DRAW, 1'b0, 32'h1234_5678);

        // One stream is drawn past a full state so that it twists again without a reseed.
        run_phase(32'd1, 800, 0, 85);
        run_phase(32'hffff_ffff, 400, 10, 50);
        calm = 1'b1;
        run_phase($urandom | 32'd1, 300, 5, 50);
        calm = 1'b0;
        // A zero default leaves an all-zero state, so every such draw yields zero.
        run_phase(32'd0, 150, 10, 50);
        settle_all();

        $display("Covered %0d seed words and %0d draws under %0d default_seed settings.",
                 sb.seeds_seen, sb.draws_seen, settings_used);
        $display("The predicted state went through %0d full twists; %0d mismatches seen.",
                 sb.twists_done, sb.mismatches);
        if (sb.expected_words.size() != 0) begin
            $display("%0d expected random words never arrived.", sb.expected_words.size());
        end
        if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
